### src/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the motor speed PID unit: payload widths,
// command and register codes, sequencer states and arithmetic constants.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int SPEED_W = 32;
    localparam int TIME_W  = 32;
    localparam int GAIN_W  = 32;
    localparam int PWM_W   = 9;
    localparam int CFG_IDX_W = 2;

    // shared multiplier and divider widths
    localparam int MUL_W         = 32;
    localparam int DIV_W         = 64;
    localparam int DIVISOR_W     = 32;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES    = DIV_W / DIV_STEP_BITS;

    // signed accumulator for the three gain products
    localparam int ACC_W = 97;

    localparam logic [DIVISOR_W-1:0] MICROS_PER_SEC = 32'd1000000;
    localparam int DZ_SCALE   = 1000;
    localparam int PWM_LEVELS = 256;

    localparam logic CMD_STEP  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P  = 2'd0,
        CFG_GAIN_I  = 2'd1,
        CFG_GAIN_D  = 2'd2,
        CFG_REVERSE = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MAG,
        ST_INC_MUL,
        ST_INC_START,
        ST_INC_DIV,
        ST_INTEG,
        ST_RATE_DIV,
        ST_SUM,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // partial products of the output sum
    typedef enum logic [2:0] {
        PP_P,
        PP_I_LO,
        PP_I_HI,
        PP_D_LO,
        PP_D_HI
    } t_part;

endpackage

### src/msp_step_if.sv
// ----------------------------------------------------------------------------
// msp_step_if
// Input channel: one control step or clear command per word.
// ----------------------------------------------------------------------------
interface msp_step_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 command;
    logic signed [msp_pkg::SPEED_W-1:0]   speed_target;
    logic signed [msp_pkg::SPEED_W-1:0]   speed_measured;
    logic        [msp_pkg::TIME_W-1:0]    time_now_us;

    modport source (
        output valid, command, speed_target, speed_measured, time_now_us,
        input  ready
    );
    modport sink (
        input  valid, command, speed_target, speed_measured, time_now_us,
        output ready
    );
endinterface

### src/msp_result_if.sv
// ----------------------------------------------------------------------------
// msp_result_if
// Output channel: one signed pwm duty word per control step.
// ----------------------------------------------------------------------------
interface msp_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [msp_pkg::PWM_W-1:0]   pwm_drive;

    modport source (
        output valid, pwm_drive,
        input  ready
    );
    modport sink (
        input  valid, pwm_drive,
        output ready
    );
endinterface

### src/msp_cfg_if.sv
// ----------------------------------------------------------------------------
// msp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface msp_cfg_if;
    logic                           valid;
    logic                           ready;
    msp_pkg::t_cfg_index            index;
    logic [msp_pkg::GAIN_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### src/msp_mul.sv
// ----------------------------------------------------------------------------
// msp_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module msp_mul (
    input  logic                           i_clk,
    input  logic [msp_pkg::MUL_W-1:0]      i_a,
    input  logic [msp_pkg::MUL_W-1:0]      i_b,
    output logic [2*msp_pkg::MUL_W-1:0]    o_prod
);
    import msp_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

### src/msp_div.sv
// ----------------------------------------------------------------------------
// msp_div
// Shared unsigned restoring divider, two quotient bits per cycle.
// The quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module msp_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [msp_pkg::DIV_W-1:0]       i_dividend,
    input  logic [msp_pkg::DIVISOR_W-1:0]   i_divisor,
    output logic                            o_done,
    output logic [msp_pkg::DIV_W-1:0]       o_quotient
);
    import msp_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYCLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIVISOR_W-1:0] r_div;

    always_comb begin
        logic [DIVISOR_W:0] trial;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_STEP_BITS; k++) begin
            trial = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### src/motor_speed_pid_unit.sv
// ----------------------------------------------------------------------------
// motor_speed_pid_unit
// Speed PID controller in signed fixed point, run by a small sequencer
// around one shared multiplier and one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   i_step carries one word per control step: command, target speed,
//   measured speed (Q16.16 by default) and a microsecond timestamp.
//   A clear command empties the integral and the previous error at once
//   and gives no result word; the unit is ready again the next cycle.
//   A control step gives one signed pwm word on o_result, and the unit
//   takes the next word in the cycle after that result is loaded. The
//   shared divider makes two quotient bits a cycle and runs twice per
//   step (integral increment, then derivative rate).
//   i_step is not ready while a step is in work. A finished result sits in
//   the output register; the next step is accepted and worked on while the
//   receiver stalls, and only its final load waits for that register.
//   i_cfg writes the gains and the direction bit and is always ready; the
//   user must write it only while idle; the unit itself does not enforce it.
//   Reset clears the gains, the direction, the integral, the previous
//   error and the last timestamp; no clearing pass is needed.
// ----------------------------------------------------------------------------
module motor_speed_pid_unit #(
    parameter int FRAC_BITS      = 16,
    parameter int INTEGRAL_WIDTH = 48,
    parameter int DT_FLOOR_US    = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    msp_step_if.sink            i_step,
    msp_result_if.source        o_result,
    msp_cfg_if.sink             i_cfg
);
    import msp_pkg::*;

    localparam int IW = INTEGRAL_WIDTH;

    localparam logic signed [33:0] DZ_LIMIT = 34'(((1 << FRAC_BITS) - 1) / DZ_SCALE + 1);
    localparam logic signed [33:0] ERR_MAX  = 34'sd2147483647;
    localparam logic [TIME_W-1:0]  DT_FLOOR = TIME_W'(DT_FLOOR_US);
    localparam logic signed [64:0] INT_MAX  = (65'sd1 <<< (IW - 1)) - 65'sd1;
    localparam logic signed [64:0] INT_MIN  = -INT_MAX - 65'sd1;
    localparam logic signed [ACC_W-1:0] PWM_SAT =
        ACC_W'(PWM_LEVELS) << (2 * FRAC_BITS);

    // sequencer
    t_state r_state, n_state;
    t_part  r_part;

    // step state
    logic [TIME_W-1:0]      r_last;
    logic signed [31:0]     r_prev;
    logic signed [IW-1:0]   r_integ;

    // configuration
    logic [GAIN_W-1:0]      r_gp_mag, r_gi_mag, r_gd_mag;
    logic                   r_gp_neg, r_gi_neg, r_gd_neg;
    logic                   r_rev;

    // working registers
    logic [SPEED_W-1:0]     r_abs_t, r_abs_m;
    logic [TIME_W-1:0]      r_dt;
    logic signed [31:0]     r_err;
    logic [31:0]            r_err_mag;
    logic signed [32:0]     r_derr;
    logic [31:0]            r_derr_mag;
    logic [63:0]            r_integ_mag;
    logic signed [ACC_W-1:0] r_acc;
    logic                   r_pp_valid, r_pp_neg, r_pp_hi;
    logic                   r_out_valid;
    logic signed [PWM_W-1:0] r_pwm;

    // combinational controls
    logic                   step_ready;
    logic                   step_acc;
    logic                   cfg_we;
    logic                   div_start;
    logic [DIVISOR_W-1:0]   div_divisor;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     prod;
    logic                   pp_valid, pp_neg, pp_hi;
    logic                   out_load;

    // datapath helpers
    logic [TIME_W-1:0]      dt_raw;
    logic signed [33:0]     diff;
    logic signed [31:0]     err_next;
    logic signed [63:0]     inc;
    logic signed [64:0]     integ_sum;
    logic signed [IW-1:0]   integ_next;
    logic [IW-1:0]          integ_abs;
    logic [ACC_W-1:0]       pp_ext;
    logic [7:0]             pwm_mag;
    logic [PWM_W-1:0]       pwm_word;

    assign step_acc = i_step.valid && step_ready;
    assign cfg_we   = i_cfg.valid && i_cfg.ready;

    msp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    msp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        step_ready  = 1'b0;
        div_start   = 1'b0;
        div_divisor = MICROS_PER_SEC;
        mul_a       = r_derr_mag;
        mul_b       = MICROS_PER_SEC;
        pp_valid    = 1'b0;
        pp_neg      = 1'b0;
        pp_hi       = 1'b0;
        out_load    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                step_ready = 1'b1;
                if (i_step.valid && i_step.command == CMD_STEP) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                n_state = ST_MAG;
            end
            ST_MAG: begin
                n_state = ST_INC_MUL;
            end
            ST_INC_MUL: begin
                mul_a   = r_err_mag;
                mul_b   = r_dt;
                n_state = ST_INC_START;
            end
            ST_INC_START: begin
                // |err| * dt is in the product register, divide by 1e6
                div_start = 1'b1;
                n_state   = ST_INC_DIV;
            end
            ST_INC_DIV: begin
                if (div_done) begin
                    n_state = ST_INTEG;
                end
            end
            ST_INTEG: begin
                // |derr| * 1e6 is held in the product register, divide by dt
                div_start   = 1'b1;
                div_divisor = r_dt;
                n_state     = ST_RATE_DIV;
            end
            ST_RATE_DIV: begin
                if (div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                pp_valid = 1'b1;
                unique case (r_part)
                    PP_P: begin
                        mul_a  = r_gp_mag;
                        mul_b  = r_err_mag;
                        pp_neg = r_gp_neg ^ r_err[31];
                    end
                    PP_I_LO: begin
                        mul_a  = r_gi_mag;
                        mul_b  = r_integ_mag[31:0];
                        pp_neg = r_gi_neg ^ r_integ[IW-1];
                    end
                    PP_I_HI: begin
                        mul_a  = r_gi_mag;
                        mul_b  = r_integ_mag[63:32];
                        pp_neg = r_gi_neg ^ r_integ[IW-1];
                        pp_hi  = 1'b1;
                    end
                    PP_D_LO: begin
                        mul_a  = r_gd_mag;
                        mul_b  = div_quo[31:0];
                        pp_neg = r_gd_neg ^ r_derr[32];
                    end
                    PP_D_HI: begin
                        mul_a  = r_gd_mag;
                        mul_b  = div_quo[63:32];
                        pp_neg = r_gd_neg ^ r_derr[32];
                        pp_hi  = 1'b1;
                    end
                endcase
                if (r_part == PP_D_HI) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    // error with dead zone and upper saturation
    always_comb begin
        diff = $signed({2'b00, r_abs_t}) - $signed({2'b00, r_abs_m});
        if (diff > -DZ_LIMIT && diff < DZ_LIMIT) begin
            err_next = '0;
        end else if (diff > ERR_MAX) begin
            err_next = 32'(ERR_MAX);
        end else begin
            err_next = 32'(diff);
        end
    end

    // saturating integral update
    always_comb begin
        inc = r_err[31] ? -$signed(div_quo) : $signed(div_quo);
        integ_sum = 65'(r_integ) + 65'(inc);
        if (integ_sum > INT_MAX) begin
            integ_next = IW'(INT_MAX);
        end else if (integ_sum < INT_MIN) begin
            integ_next = IW'(INT_MIN);
        end else begin
            integ_next = IW'(integ_sum);
        end
        integ_abs = r_integ[IW-1] ? IW'(-r_integ) : IW'(r_integ);
    end

    assign dt_raw = i_step.time_now_us - r_last;
    assign pp_ext = r_pp_hi ? {1'b0, prod, 32'd0} : ACC_W'(prod);

    // clamp, truncate and apply direction
    always_comb begin
        priority if (r_acc[ACC_W-1]) begin
            pwm_mag = '0;
        end else if (r_acc >= PWM_SAT) begin
            pwm_mag = 8'(PWM_LEVELS - 1);
        end else begin
            pwm_mag = r_acc[2*FRAC_BITS +: 8];
        end
        pwm_word = r_rev ? PWM_W'(-{1'b0, pwm_mag}) : {1'b0, pwm_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_prev      <= '0;
            r_integ     <= '0;
            r_gp_mag    <= '0;
            r_gi_mag    <= '0;
            r_gd_mag    <= '0;
            r_gp_neg    <= 1'b0;
            r_gi_neg    <= 1'b0;
            r_gd_neg    <= 1'b0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pp_valid  <= 1'b0;
            r_part      <= PP_P;
        end else begin
            if (cfg_we) begin
                unique case (i_cfg.index)
                    CFG_GAIN_P: begin
                        r_gp_neg <= i_cfg.data[GAIN_W-1];
                        r_gp_mag <= i_cfg.data[GAIN_W-1] ? -i_cfg.data : i_cfg.data;
                    end
                    CFG_GAIN_I: begin
                        r_gi_neg <= i_cfg.data[GAIN_W-1];
                        r_gi_mag <= i_cfg.data[GAIN_W-1] ? -i_cfg.data : i_cfg.data;
                    end
                    CFG_GAIN_D: begin
                        r_gd_neg <= i_cfg.data[GAIN_W-1];
                        r_gd_mag <= i_cfg.data[GAIN_W-1] ? -i_cfg.data : i_cfg.data;
                    end
                    CFG_REVERSE: begin
                        r_rev <= i_cfg.data[0];
                    end
                endcase
            end
            if (step_acc) begin
                if (i_step.command == CMD_CLEAR) begin
                    r_integ <= '0;
                    r_prev  <= '0;
                end else begin
                    r_last <= i_step.time_now_us;
                    if (i_step.speed_target == '0) begin
                        r_integ <= '0;
                    end
                end
            end
            if (r_state == ST_INTEG) begin
                r_integ <= integ_next;
            end
            if (r_state == ST_RATE_DIV) begin
                r_part <= PP_P;
            end else if (r_state == ST_SUM && r_part != PP_D_HI) begin
                r_part <= t_part'(r_part + 1'b1);
            end
            r_pp_valid <= pp_valid;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_err;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_acc) begin
            r_abs_t <= i_step.speed_target[SPEED_W-1] ?
                       SPEED_W'(-i_step.speed_target) : SPEED_W'(i_step.speed_target);
            r_abs_m <= i_step.speed_measured[SPEED_W-1] ?
                       SPEED_W'(-i_step.speed_measured) : SPEED_W'(i_step.speed_measured);
            r_dt    <= (dt_raw == '0) ? DT_FLOOR : dt_raw;
        end
        if (r_state == ST_ERR) begin
            r_err <= err_next;
            r_acc <= '0;
        end
        if (r_state == ST_MAG) begin
            r_err_mag <= r_err[31] ? 32'(-r_err) : 32'(r_err);
            r_derr    <= 33'(r_err) - 33'(r_prev);
        end
        if (r_state == ST_INC_MUL) begin
            r_derr_mag <= r_derr[32] ? 32'(-r_derr) : 32'(r_derr);
        end
        if (r_state == ST_RATE_DIV) begin
            r_integ_mag <= 64'(integ_abs);
        end
        r_pp_neg <= pp_neg;
        r_pp_hi  <= pp_hi;
        if (r_pp_valid) begin
            r_acc <= r_pp_neg ? r_acc - $signed(pp_ext) : r_acc + $signed(pp_ext);
        end
        if (out_load) begin
            r_pwm <= pwm_word;
        end
    end

    assign i_step.ready      = step_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_result.valid    = r_out_valid;
    assign o_result.pwm_drive = r_pwm;

`ifndef SYNTHESIS
    // magnitude never exceeds 255
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.pwm_drive != -9'sd256)
        else $error("pwm word out of range");

    a_pwm_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !r_rev) |-> !o_result.pwm_drive[PWM_W-1])
        else $error("negative pwm word in forward direction");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_INC_DIV || r_state == ST_RATE_DIV))
        else $error("divider finished outside a wait state");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_acc && i_step.command == CMD_CLEAR) |=> (r_integ == '0 && r_prev == '0))
        else $error("clear command did not empty the integral");
`endif

endmodule
